// ===== rtl/core/u16u8_pkg.sv =====
// ---------------------------------------------------------------------------
// u16u8_pkg: shared types and constants for the UTF-16 to UTF-8 transcoder
// Code point queue entry, UTF-16 range limits and UTF-8 byte formation.
// ---------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;
  localparam int unsigned LenW   = 2;   // encoded length minus one
  localparam int unsigned ByteW  = 8;

  localparam logic [UnitW-1:0] HiSurFirst = 16'hD800;
  localparam logic [UnitW-1:0] HiSurLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LoSurFirst = 16'hDC00;
  localparam logic [UnitW-1:0] LoSurLast  = 16'hDFFF;
  localparam logic [PointW-1:0] PlaneBase = 21'h10000;

  localparam logic [PointW-1:0] Max1Byte = 21'h7F;
  localparam logic [PointW-1:0] Max2Byte = 21'h7FF;
  localparam logic [PointW-1:0] Max3Byte = 21'hFFFF;

  // Encoded length codes (bytes minus one)
  localparam logic [LenW-1:0] Len1 = 2'd0;
  localparam logic [LenW-1:0] Len2 = 2'd1;
  localparam logic [LenW-1:0] Len3 = 2'd2;
  localparam logic [LenW-1:0] Len4 = 2'd3;

  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] Cont  = 8'h80;

  typedef struct packed {
    logic [PointW-1:0] point;
    logic [LenW-1:0]   len;
  } cp_item_t;

  localparam int unsigned ItemW = $bits(cp_item_t);

  // Byte idx (0 = lead) of the encoding of point, length code len.
  function automatic logic [ByteW-1:0] utf8_byte(input logic [PointW-1:0] point,
                                                 input logic [LenW-1:0] len,
                                                 input logic [LenW-1:0] idx);
    logic [LenW-1:0]  rem;
    logic [ByteW-1:0] res;
    rem = len - idx;
    res = '0;
    if (idx == Len1) begin
      case (len)
        Len1:    res = {1'b0, point[6:0]};
        Len2:    res = Lead2 | {3'b000, point[10:6]};
        Len3:    res = Lead3 | {4'b0000, point[15:12]};
        Len4:    res = Lead4 | {5'b00000, point[20:18]};
        default: res = '0;
      endcase
    end else begin
      case (rem)
        2'd0:    res = Cont | {2'b00, point[5:0]};
        2'd1:    res = Cont | {2'b00, point[11:6]};
        2'd2:    res = Cont | {2'b00, point[17:12]};
        default: res = Cont;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/u16u8_front.sv =====
// ---------------------------------------------------------------------------
// u16u8_front: code unit intake and classification
// Tracks the pending surrogate value and pushes complete code points,
// tagged with their UTF-8 length, into the queue.
// ---------------------------------------------------------------------------
module u16u8_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [u16u8_pkg::UnitW-1:0]       code_unit_i,
  output logic                              push_o,
  output u16u8_pkg::cp_item_t               push_item_o,
  input  logic                              push_ready_i
);

  logic [u16u8_pkg::PointW-1:0] pending_q, pending_d;
  logic [u16u8_pkg::PointW-1:0] cp;
  logic is_zero, is_hi, is_lo, accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  assign is_zero = (code_unit_i == '0);
  assign is_hi   = (code_unit_i >= u16u8_pkg::HiSurFirst) &&
                   (code_unit_i <= u16u8_pkg::HiSurLast);
  assign is_lo   = (code_unit_i >= u16u8_pkg::LoSurFirst) &&
                   (code_unit_i <= u16u8_pkg::LoSurLast);

  // Surrogate offsets are the low ten bits of the unit.
  always_comb begin
    if (is_lo) begin
      cp = pending_q | {11'd0, code_unit_i[9:0]};
    end else begin
      cp = {5'd0, code_unit_i};
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (accept) begin
      if (is_hi) begin
        pending_d = {1'b0, code_unit_i[9:0], 10'd0} + u16u8_pkg::PlaneBase;
      end else begin
        pending_d = '0;
      end
    end
  end

  always_comb begin
    push_item_o.point = cp;
    if (cp <= u16u8_pkg::Max1Byte) begin
      push_item_o.len = u16u8_pkg::Len1;
    end else if (cp <= u16u8_pkg::Max2Byte) begin
      push_item_o.len = u16u8_pkg::Len2;
    end else if (cp <= u16u8_pkg::Max3Byte) begin
      push_item_o.len = u16u8_pkg::Len3;
    end else begin
      push_item_o.len = u16u8_pkg::Len4;
    end
  end

  assign push_o = accept && !is_zero && !is_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

// ===== rtl/core/u16u8_fifo.sv =====
// ---------------------------------------------------------------------------
// u16u8_fifo: short register queue
// Decouples the intake side from the byte serializer.
// ---------------------------------------------------------------------------
module u16u8_fifo #(
  parameter int unsigned Width = 23,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             pop_valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/u16u8_back.sv =====
// ---------------------------------------------------------------------------
// u16u8_back: UTF-8 byte serializer
// Walks one queued code point byte by byte into a registered output stage.
// ---------------------------------------------------------------------------
module u16u8_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  input  u16u8_pkg::cp_item_t         pop_item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u16u8_pkg::ByteW-1:0] out_byte_o,
  output logic                        last_byte_o
);

  logic                          busy_q;
  logic [u16u8_pkg::PointW-1:0]  point_q;
  logic [u16u8_pkg::LenW-1:0]    len_q, idx_q;
  logic                          out_valid_q, out_last_q;
  logic [u16u8_pkg::ByteW-1:0]   out_byte_q;
  logic                          advance, is_last;

  assign advance = busy_q && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == len_q);
  // Load the next code point while the final byte of this one goes out.
  assign pop_o   = pop_valid_i && (!busy_q || (advance && is_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (advance) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      point_q <= pop_item_i.point;
      len_q   <= pop_item_i.len;
    end
    if (advance) begin
      out_byte_q <= u16u8_pkg::utf8_byte(point_q, len_q, idx_q);
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// Throughput: one UTF-8 byte per cycle from the serializer while out_ready_i is high and
//   code points are queued; high surrogates and zero units are taken but emit nothing.
// Reset (rst_ni low, async): pending surrogate cleared, queue and output emptied.
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder: UTF-16 code unit stream to UTF-8 byte stream
// Front end pairs surrogates and sizes code points, a short queue decouples
// it from the back end, which serializes bytes into an output register.
// ---------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
  parameter int unsigned QueueDepth = 4   // code points buffered between stages
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel: one UTF-16 code unit per transfer
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [u16u8_pkg::UnitW-1:0] code_unit_i,
  // output channel: one UTF-8 byte per transfer
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u16u8_pkg::ByteW-1:0] out_byte_o,
  output logic                        last_byte_o
);

  logic                 push, push_ready, pop, pop_valid;
  u16u8_pkg::cp_item_t  push_item, pop_item;

  // Intake: a unit is taken whenever the queue has room, even if it emits nothing.
  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Queue of complete code points with their encoded length.
  u16u8_fifo #(
    .Width (u16u8_pkg::ItemW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_item),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_data_o   (pop_item),
    .pop_valid_o  (pop_valid)
  );

  // Serializer: one byte per cycle while code points are queued, stalls only on out_ready_i.
  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// ===== rtl/core/u16u8_checker.sv =====
// ---------------------------------------------------------------------------
// u16u8_checker: port-level checks for the transcoder
// Output handshake stability and UTF-8 sequence framing.
// ---------------------------------------------------------------------------
module u16u8_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [u16u8_pkg::ByteW-1:0] out_byte_o,
  input logic                        last_byte_o
);

  logic out_xfer, mid_q;

  assign out_xfer = out_valid_o && out_ready_i;

  // Set between the first and final byte of one code point's encoding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (out_xfer) begin
      mid_q <= !last_byte_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(last_byte_o))
    else $error("output changed while stalled");

  a_cont_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && mid_q |-> out_byte_o[7:6] == 2'b10)
    else $error("lead byte inside a sequence");

  a_lead_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !mid_q |-> out_byte_o[7:6] != 2'b10)
    else $error("continuation byte starts a sequence");

  a_ascii_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_byte_o[7] |-> last_byte_o)
    else $error("single-byte code point not marked last");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_byte_o (last_byte_o)
);
